FILE: design/jse_pkg.sv
// Shared types, constants and helpers of the JSON string escaper.
// Used by the front, queue and back modules and by the top level.
package jse_pkg;

  localparam int unsigned FifoDepth  = 2;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCountW = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] CtrlMax     = 8'h1F;

  // How the content bytes of one entry are escaped.
  typedef enum logic [1:0] {
    EscNone = 2'd0,
    EscPair = 2'd1,
    EscHex  = 2'd2
  } esc_e;

  // One classified input item, queued between front and back.
  typedef struct packed {
    logic            str_start;
    logic            str_end;
    logic            dangling;
    esc_e            esc;
    logic [7:0]      esc_char;
    logic [2:0]      content_len;
    logic [3:0]      total;
    logic [3:0][7:0] bytes;
  } entry_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = ChZero + {4'd0, nib};
    end else begin
      r = ChLowerA + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

FILE: design/jse_if.sv
// Valid/ready channel interfaces of the JSON string escaper.
// No dependencies.
interface jse_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_present;
  logic        string_start;
  logic        string_end;

  modport source (output valid, code_unit, unit_present, string_start, string_end,
                  input ready);
  modport sink   (input valid, code_unit, unit_present, string_start, string_end,
                  output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       closing_quote;
  logic       dangling_surrogate;

  modport source (output valid, out_byte, run_last, closing_quote, dangling_surrogate,
                  input ready);
  modport sink   (input valid, out_byte, run_last, closing_quote, dangling_surrogate,
                  output ready);
endinterface

FILE: design/jse_front.sv
// Front end: accepts code units, converts UTF-16 to UTF-8 or passes bytes, classifies escapes.
// Depends on jse_pkg and jse_in_if.
module jse_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  jse_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output jse_pkg::entry_t entry_o
);
  import jse_pkg::*;

  logic        fmt_q;
  logic        held_valid_q, held_valid_d;
  logic [9:0]  held_bits_q, held_bits_d;
  logic [25:0] cp;
  logic [2:0]  nbytes;
  logic [3:0][7:0] bytes;
  logic        dangling;
  esc_e        esc;
  logic [7:0]  esc_char;
  logic [2:0]  clen;
  logic [3:0]  total;
  logic        accept;
  logic [15:0] u;

  assign u      = in_i.code_unit;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !full_i;

  // Only bits 25:0 of the code point reach the output bytes.
  assign cp = {6'd0, held_bits_q, 10'd0} + ({10'd0, u} - 26'h00DC00) + 26'h010000;

  always_comb begin
    nbytes       = 3'd0;
    bytes        = '0;
    held_valid_d = held_valid_q;
    held_bits_d  = held_bits_q;
    dangling     = 1'b0;
    if (in_i.unit_present) begin
      if (fmt_q) begin
        nbytes   = 3'd1;
        bytes[0] = u[7:0];
      end else if (held_valid_q) begin
        nbytes       = 3'd4;
        bytes[0]     = 8'hF0 | cp[25:18];
        bytes[1]     = 8'h80 | {2'b00, cp[17:12]};
        bytes[2]     = 8'h80 | {2'b00, cp[11:6]};
        bytes[3]     = 8'h80 | {2'b00, cp[5:0]};
        held_valid_d = 1'b0;
        held_bits_d  = '0;
      end else if (u <= 16'h007F) begin
        nbytes   = 3'd1;
        bytes[0] = u[7:0];
      end else if (u <= 16'h07FF) begin
        nbytes   = 3'd2;
        bytes[0] = 8'hC0 | {3'b000, u[10:6]};
        bytes[1] = 8'h80 | {2'b00, u[5:0]};
      end else if (u < 16'hD800 || u > 16'hDBFF) begin
        nbytes   = 3'd3;
        bytes[0] = 8'hE0 | {4'h0, u[15:12]};
        bytes[1] = 8'h80 | {2'b00, u[11:6]};
        bytes[2] = 8'h80 | {2'b00, u[5:0]};
      end else begin
        held_valid_d = 1'b1;
        held_bits_d  = u[9:0];
      end
    end
    // A high half still waiting at the string end is dropped.
    if (in_i.string_end && held_valid_d) begin
      dangling     = 1'b1;
      held_valid_d = 1'b0;
      held_bits_d  = '0;
    end
  end

  // Multi-byte sequences never contain bytes that need escaping.
  always_comb begin
    esc      = EscNone;
    esc_char = '0;
    if (nbytes == 3'd1) begin
      case (bytes[0])
        ChNewline:   begin esc = EscPair; esc_char = ChLowerN;    end
        ChReturn:    begin esc = EscPair; esc_char = ChLowerR;    end
        ChTab:       begin esc = EscPair; esc_char = ChLowerT;    end
        ChBackslash: begin esc = EscPair; esc_char = ChBackslash; end
        ChQuote:     begin esc = EscPair; esc_char = ChQuote;     end
        default: begin
          if (bytes[0] <= CtrlMax) begin
            esc = EscHex;
          end
        end
      endcase
    end
  end

  always_comb begin
    case (esc)
      EscPair: clen = 3'd2;
      EscHex:  clen = 3'd6;
      default: clen = nbytes;
    endcase
  end

  assign total = {3'd0, in_i.string_start} + {1'b0, clen} + {3'd0, in_i.string_end};

  assign push_o = accept && (total != 4'd0);

  always_comb begin
    entry_o.str_start   = in_i.string_start;
    entry_o.str_end     = in_i.string_end;
    entry_o.dangling    = dangling;
    entry_o.esc         = esc;
    entry_o.esc_char    = esc_char;
    entry_o.content_len = clen;
    entry_o.total       = total;
    entry_o.bytes       = bytes;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= 1'b0;
      held_valid_q <= 1'b0;
      held_bits_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      if (accept) begin
        held_valid_q <= held_valid_d;
        held_bits_q  <= held_bits_d;
      end
    end
  end

endmodule

FILE: design/jse_fifo.sv
// Short queue of classified entries between the front and the back end.
// Depends on jse_pkg.
module jse_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jse_pkg::entry_t entry_i,
  input  logic            pop_i,
  output jse_pkg::entry_t entry_o,
  output logic            empty_o,
  output logic            full_o
);
  import jse_pkg::*;

  entry_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCountW-1:0] count_q;

  function automatic logic [FifoPtrW-1:0] ptr_next(input logic [FifoPtrW-1:0] p);
    logic [FifoPtrW-1:0] r;
    if (p == FifoPtrW'(FifoDepth - 1)) begin
      r = '0;
    end else begin
      r = p + FifoPtrW'(1);
    end
    return r;
  endfunction

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == FifoCountW'(FifoDepth));
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FifoCountW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FifoCountW'(1);
      end
    end
  end

endmodule

FILE: design/jse_back.sv
// Back end: expands one queued entry into output bytes, one per cycle while out_o is ready.
// Depends on jse_pkg and jse_out_if.
module jse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jse_pkg::entry_t entry_i,
  input  logic            empty_i,
  output logic            pop_o,
  jse_out_if.source       out_o
);
  import jse_pkg::*;

  logic [2:0] idx_q;
  logic [2:0] k;
  logic       advance;
  logic       last;
  logic [7:0] byte_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q, closing_q, dangling_q;

  assign advance = !empty_i && (!out_valid_q || out_o.ready);
  assign last    = ({1'b0, idx_q} == (entry_i.total - 4'd1));
  assign pop_o   = advance && last;
  assign k       = idx_q - {2'd0, entry_i.str_start};

  always_comb begin
    if (entry_i.str_start && idx_q == 3'd0) begin
      byte_d = ChQuote;
    end else if (k < entry_i.content_len) begin
      case (entry_i.esc)
        EscPair: byte_d = (k == 3'd0) ? ChBackslash : entry_i.esc_char;
        EscHex: begin
          case (k)
            3'd0:    byte_d = ChBackslash;
            3'd1:    byte_d = ChLowerU;
            3'd4:    byte_d = hex_char(entry_i.bytes[0][7:4]);
            3'd5:    byte_d = hex_char(entry_i.bytes[0][3:0]);
            default: byte_d = ChZero;
          endcase
        end
        default: byte_d = entry_i.bytes[k[1:0]];
      endcase
    end else begin
      byte_d = ChQuote;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_d;
      run_last_q <= last;
      closing_q  <= last && entry_i.str_end;
      dangling_q <= last && entry_i.str_end && entry_i.dangling;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 3'd0 : idx_q + 3'd1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.out_byte           = out_byte_q;
  assign out_o.run_last           = run_last_q;
  assign out_o.closing_quote      = closing_q;
  assign out_o.dangling_surrogate = dangling_q;

endmodule

FILE: design/json_string_escaper_utf16.sv
// JSON string escaper, UTF-16 or byte input to quoted, escaped UTF-8 output.
// Input channel in_i carries one code unit with presence, string start and
// string end flags; output channel out_o carries one byte per transaction,
// tagged with the last byte of its item, the closing quote, and a flag on the
// closing quote when a pending high surrogate was dropped.
// cfg_we_i/cfg_wdata_i write the source format: 0 for UTF-16, 1 for bytes.
// An accepted item is classified in the same cycle and, if it yields any
// byte, queued in a two-entry queue; its bytes reach out_o through the
// output register. The back end sends one byte per cycle while out_o is
// ready; an item yields 1 to 8 bytes, and one that yields none is not queued.
// Input is accepted every cycle while the queue has room, so items flow back
// to back as long as each yields at most one byte on average and out_o is ready.
// When the receiver stalls, the output register holds its byte, the queue
// fills and in_i.ready drops after at most two more items; only one more when
// the held byte is not the last one of its item, whose entry stays queued.
// Reset clears the queue, the output valid, the held surrogate and selects
// UTF-16 input.
// Depends on jse_pkg, jse_if, jse_front, jse_fifo and jse_back.
module json_string_escaper_utf16 (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  jse_in_if.sink    in_i,
  jse_out_if.source out_o
);
  import jse_pkg::*;

  entry_t push_entry, head_entry;
  logic   push, pop, fifo_empty, fifo_full;

  jse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .full_i      (fifo_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  jse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  jse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .empty_i (fifo_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

`ifndef NO_ASSERTIONS
  a_closing_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.closing_quote) |-> out_o.run_last)
    else $error("closing quote not marked as last byte of its item");

  a_dangling_on_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.dangling_surrogate) |-> out_o.closing_quote)
    else $error("dangling surrogate flag outside a closing quote");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_empty)
    else $error("back end popped an empty queue");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full)
    else $error("front end pushed into a full queue");
`endif

endmodule

FILE: tb/sv/tb_json_string_escaper_utf16.sv
// Testbench for json_string_escaper_utf16: drives code units through in_i and checks
// every escaped byte on out_o against a predictor kept inside the testbench.
// Depends on jse_pkg, jse_if and the escaper RTL.
module tb_json_string_escaper_utf16;
  timeunit 1ns;
  timeprecision 1ps;

  import jse_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles  = 8;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       closing;
    logic       dangling;
  } esc_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  jse_in_if  in_if ();
  jse_out_if out_if ();

  json_string_escaper_utf16 u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state, mirrors the block's configuration and surrogate register.
  logic       src_is_bytes  = 1'b0;
  logic [9:0] held_high     = 10'd0;
  logic       held_pending  = 1'b0;
  logic [7:0] item_bytes[$];
  esc_byte_t  escaped_q[$];

  bit          idle_en = 1'b1;
  int unsigned mismatch_count  = 0;
  int unsigned items_sent      = 0;
  int unsigned byte_mode_items = 0;
  int unsigned bytes_checked   = 0;
  int unsigned dropped_seen    = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned stall_left      = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void push_escaped(input logic [7:0] b);
    case (b)
      ChNewline:   begin item_bytes.push_back(ChBackslash); item_bytes.push_back(ChLowerN); end
      ChReturn:    begin item_bytes.push_back(ChBackslash); item_bytes.push_back(ChLowerR); end
      ChTab:       begin item_bytes.push_back(ChBackslash); item_bytes.push_back(ChLowerT); end
      ChBackslash: begin item_bytes.push_back(ChBackslash); item_bytes.push_back(ChBackslash); end
      ChQuote:     begin item_bytes.push_back(ChBackslash); item_bytes.push_back(ChQuote); end
      default: begin
        if (b <= CtrlMax) begin
          item_bytes.push_back(ChBackslash);
          item_bytes.push_back(ChLowerU);
          item_bytes.push_back(ChZero);
          item_bytes.push_back(ChZero);
          // Upper nibble is 0 or 1 here, lower nibble may need a letter.
          item_bytes.push_back(ChZero + {7'd0, b[4]});
          item_bytes.push_back((b[3:0] < 4'd10) ? ChZero + {4'd0, b[3:0]}
                                                : ChLowerA + {4'd0, b[3:0]} - 8'd10);
        end else begin
          item_bytes.push_back(b);
        end
      end
    endcase
  endfunction

  function automatic void push_utf16(input logic [15:0] w);
    logic [31:0] cp;
    if (held_pending) begin
      // Whatever follows a high surrogate is taken as the low half; the sum wraps.
      cp = {12'd0, held_high, 10'd0} + ({16'd0, w} - 32'h0000_DC00) + 32'h0001_0000;
      held_pending = 1'b0;
      held_high    = 10'd0;
      push_escaped(8'hF0 | cp[25:18]);
      push_escaped({2'b10, cp[17:12]});
      push_escaped({2'b10, cp[11:6]});
      push_escaped({2'b10, cp[5:0]});
    end else if (w <= 16'h007F) begin
      push_escaped(w[7:0]);
    end else if (w <= 16'h07FF) begin
      push_escaped({3'b110, w[10:6]});
      push_escaped({2'b10, w[5:0]});
    end else if (w < 16'hD800 || w > 16'hDBFF) begin
      push_escaped({4'hE, w[15:12]});
      push_escaped({2'b10, w[11:6]});
      push_escaped({2'b10, w[5:0]});
    end else begin
      held_high    = w[9:0];
      held_pending = 1'b1;
    end
  endfunction

  function automatic void predict_escape(input logic [15:0] unit, input logic present,
                                         input logic start, input logic str_end);
    esc_byte_t rec;
    logic      dropped;
    dropped = 1'b0;
    item_bytes.delete();
    if (start) item_bytes.push_back(ChQuote);
    if (present) begin
      if (src_is_bytes) push_escaped(unit[7:0]);
      else push_utf16(unit);
    end
    if (str_end) begin
      if (held_pending) begin
        dropped      = 1'b1;
        held_pending = 1'b0;
        held_high    = 10'd0;
      end
      item_bytes.push_back(ChQuote);
    end
    foreach (item_bytes[i]) begin
      rec.value    = item_bytes[i];
      rec.last     = (i == item_bytes.size() - 1);
      rec.closing  = str_end && rec.last;
      rec.dangling = rec.closing && dropped;
      escaped_q.push_back(rec);
    end
  endfunction

  // Called at a clock edge; returns at the edge where the item was taken.
  task automatic send_unit(input logic [15:0] unit, input logic present,
                           input logic start, input logic str_end);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.code_unit    <= unit;
    in_if.unit_present <= present;
    in_if.string_start <= start;
    in_if.string_end   <= str_end;
    do @(posedge clk_i); while (!in_if.ready);
    predict_escape(unit, present, start, str_end);
    items_sent++;
    if (src_is_bytes) byte_mode_items++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk_i);
    // Items without output give no byte to wait for and are never queued.
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_source_format(input logic bytes_mode);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bytes_mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    src_is_bytes = bytes_mode;
  endtask

  function automatic logic [15:0] pick_unit(input int unsigned kind);
    logic [15:0] u;
    case (kind)
      0, 1, 2, 3: u = 16'($urandom_range(16'h20, 16'h7E));
      4:          u = 16'($urandom_range(0, 16'h1F));
      5:          u = ($urandom_range(0, 1) != 0) ? {8'h00, ChQuote} : {8'h00, ChBackslash};
      6:          u = 16'($urandom_range(16'h80, 16'h7FF));
      7: begin
        u = 16'($urandom_range(16'h800, 16'hFFFF));
        if (u >= 16'hD800 && u <= 16'hDBFF) u = 16'hE000 | u[9:0];
      end
      default:    u = 16'($urandom);
    endcase
    return u;
  endfunction

  task automatic send_random_string();
    logic [15:0] units[$];
    int unsigned n;
    int unsigned kind;
    bit          open_alone;
    bit          close_alone;
    n = $urandom_range(0, 6);
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        units.push_back(16'hD800 | 16'($urandom_range(0, 1023)));
        units.push_back(16'hDC00 | 16'($urandom_range(0, 1023)));
      end else begin
        units.push_back(pick_unit(kind));
      end
    end
    if (units.size() == 0) begin
      if ($urandom_range(0, 1) != 0) begin
        send_unit(16'($urandom), 1'b0, 1'b1, 1'b1);
      end else begin
        send_unit(16'($urandom), 1'b0, 1'b1, 1'b0);
        send_unit(16'($urandom), 1'b0, 1'b0, 1'b1);
      end
    end else begin
      open_alone  = ($urandom_range(0, 5) == 0);
      close_alone = ($urandom_range(0, 5) == 0);
      if (open_alone) send_unit(16'($urandom), 1'b0, 1'b1, 1'b0);
      foreach (units[i]) begin
        if ($urandom_range(0, 9) == 0) send_unit(16'($urandom), 1'b0, 1'b0, 1'b0);
        send_unit(units[i], 1'b1, (i == 0) && !open_alone,
                  (i == units.size() - 1) && !close_alone);
      end
      if (close_alone) send_unit(16'($urandom), 1'b0, 1'b0, 1'b1);
    end
  endtask

  task automatic test_utf16_directed();
    set_source_format(1'b0);
    send_unit(16'h0000, 1'b0, 1'b1, 1'b1);  // empty string
    send_unit(16'hFFFF, 1'b0, 1'b0, 1'b0);  // no unit, no quotes: nothing comes out
    send_unit(16'h0000, 1'b1, 1'b1, 1'b0);
    send_unit(16'h001F, 1'b1, 1'b0, 1'b0);
    send_unit(16'h000A, 1'b1, 1'b0, 1'b0);
    send_unit(16'h000D, 1'b1, 1'b0, 1'b0);
    send_unit(16'h0009, 1'b1, 1'b0, 1'b0);
    send_unit(16'h005C, 1'b1, 1'b0, 1'b0);
    send_unit(16'h0022, 1'b1, 1'b0, 1'b0);
    send_unit(16'h007F, 1'b1, 1'b0, 1'b0);
    send_unit(16'h0080, 1'b1, 1'b0, 1'b0);
    send_unit(16'h07FF, 1'b1, 1'b0, 1'b0);
    send_unit(16'h0800, 1'b1, 1'b0, 1'b0);
    send_unit(16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_unit(16'hD800, 1'b1, 1'b0, 1'b0);  // lowest pair
    send_unit(16'hDC00, 1'b1, 1'b0, 1'b0);
    send_unit(16'hDBFF, 1'b1, 1'b0, 1'b0);  // highest pair
    send_unit(16'hDFFF, 1'b1, 1'b0, 1'b0);
    send_unit(16'hD834, 1'b1, 1'b0, 1'b0);  // followed by a unit that is not a low half
    send_unit(16'h0041, 1'b1, 1'b0, 1'b1);
    send_unit(16'hD83D, 1'b1, 1'b0, 1'b0);  // held outside any string
    send_unit(16'hDE00, 1'b1, 1'b1, 1'b1);  // the opening quote does not stop it pairing with the held half
    send_unit(16'hDBC0, 1'b1, 1'b1, 1'b0);
    send_unit(16'h0000, 1'b0, 1'b0, 1'b1);  // bare close drops the pending half
  endtask

  task automatic test_byte_mode_directed();
    set_source_format(1'b1);
    send_unit(16'h0000, 1'b1, 1'b1, 1'b0);
    send_unit(16'h001F, 1'b1, 1'b0, 1'b0);
    send_unit(16'hAB5C, 1'b1, 1'b0, 1'b0);  // upper byte is ignored
    send_unit(16'h0080, 1'b1, 1'b0, 1'b0);
    send_unit(16'h00FF, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_held_across_format();
    set_source_format(1'b0);
    send_unit(16'hD801, 1'b1, 1'b1, 1'b0);
    set_source_format(1'b1);
    send_unit(16'h0041, 1'b1, 1'b0, 1'b1);  // byte mode leaves the surrogate to be dropped
  endtask

  task automatic test_random_traffic(input logic bytes_mode, input int unsigned n_items);
    int unsigned stop_at;
    set_source_format(bytes_mode);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        send_random_string();
      end else begin
        send_unit(16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_output
    esc_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (escaped_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte 0x%02h", out_if.out_byte));
      end else begin
        want = escaped_q.pop_front();
        bytes_checked++;
        if (want.dangling) dropped_seen++;
        if (out_if.out_byte !== want.value)
          report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                    out_if.out_byte, want.value));
        if (out_if.run_last !== want.last)
          report_mismatch($sformatf("run_last %b, expected %b", out_if.run_last, want.last));
        if (out_if.closing_quote !== want.closing)
          report_mismatch($sformatf("closing_quote %b, expected %b",
                                    out_if.closing_quote, want.closing));
        if (out_if.dangling_surrogate !== want.dangling)
          report_mismatch($sformatf("dangling_surrogate %b, expected %b",
                                    out_if.dangling_surrogate, want.dangling));
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no transaction for %0d cycles", WatchdogLimit);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 1'b0;
    in_if.valid        = 1'b0;
    in_if.code_unit    = 16'h0000;
    in_if.unit_present = 1'b0;
    in_if.string_start = 1'b0;
    in_if.string_end   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_utf16_directed();
    test_byte_mode_directed();
    test_held_across_format();
    test_random_traffic(1'b0, 50);
    test_random_traffic(1'b1, 40);
    test_random_traffic(1'b0, 40);
    idle_en = 1'b0;
    test_random_traffic(1'b1, 15);
    test_random_traffic(1'b0, 15);
    wait_drained();

    $display("Sent %0d items (%0d in byte mode) and checked %0d escaped bytes.",
             items_sent, byte_mode_items, bytes_checked);
    $display("Closing quotes with a dropped surrogate: %0d, mismatches: %0d.",
             dropped_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
